FILE: src/mtfd_pkg.sv
`timescale 1ns / 1ps

package mtfd_pkg;

    // Line and value capture limits
    localparam logic [5:0] MAX_LINE_CHARS = 6'd32;
    localparam logic [3:0] TEXT_CHARS     = 4'd12;
    localparam int         TEXT_SLOTS     = 12;
    localparam int         NUM_LABELS     = 10;

    // Control characters, 7-bit
    localparam logic [6:0] CH_STX   = 7'h02;
    localparam logic [6:0] CH_ETX   = 7'h03;
    localparam logic [6:0] CH_EOT   = 7'h04;
    localparam logic [6:0] CH_LF    = 7'h0A;
    localparam logic [6:0] CH_CR    = 7'h0D;
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_NINE  = 7'h39;

    localparam logic [6:0]  CSUM_OFFSET       = 7'h20;
    localparam logic [9:0]  FRAME_LIMIT_RESET = 10'd280;
    localparam logic [33:0] NUM_MAX           = 34'd999999999;

    // Event codes
    localparam logic [2:0] EV_GROUP_OK     = 3'd0;
    localparam logic [2:0] EV_FRAME_END    = 3'd1;
    localparam logic [2:0] EV_CSUM_BAD     = 3'd2;
    localparam logic [2:0] EV_LABEL_BAD    = 3'd3;
    localparam logic [2:0] EV_FRAME_LONG   = 3'd4;
    localparam logic [2:0] EV_CONN_END     = 3'd5;
    localparam logic [2:0] EV_LINE_LONG    = 3'd6;

    // Labels whose value is reported as a number
    localparam logic [NUM_LABELS-1:0] LABEL_NUMERIC = 10'h1EC;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [3:0]  field_id;
        logic [29:0] number_value;
        logic [63:0] text_head;
        logic [31:0] text_tail;
        logic [3:0]  text_length;
        logic [9:0]  group_number;
    } t_result;

    // Label text, first character in the top byte, padded with zeros
    function automatic logic [63:0] label_text(input logic [3:0] k);
        logic [63:0] t;
        unique case (k)
            4'd0:    t = {"ADCO", 32'h0};
            4'd1:    t = {"OPTARIF", 8'h0};
            4'd2:    t = {"ISOUSC", 16'h0};
            4'd3:    t = {"BASE", 32'h0};
            4'd4:    t = {"PTEC", 32'h0};
            4'd5:    t = {"IINST", 24'h0};
            4'd6:    t = {"IMAX", 32'h0};
            4'd7:    t = {"PAPP", 32'h0};
            4'd8:    t = {"ADPS", 32'h0};
            4'd9:    t = "MOTDETAT";
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [3:0] label_len(input logic [3:0] k);
        logic [3:0] n;
        unique case (k)
            4'd1:    n = 4'd7;
            4'd2:    n = 4'd6;
            4'd5:    n = 4'd5;
            4'd9:    n = 4'd8;
            default: n = 4'd4;
        endcase
        return n;
    endfunction

endpackage

FILE: src/mtfd_skid.sv
`timescale 1ns / 1ps

module mtfd_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mtfd_pkg::t_result i_data,
    output logic              o_full,
    output logic              o_valid,
    output mtfd_pkg::t_result o_data,
    input  logic              i_stall
);

    logic              r_out_valid;
    logic              r_skid_valid;
    mtfd_pkg::t_result r_out;
    mtfd_pkg::t_result r_skid;
    logic              n_out_valid;
    logic              n_skid_valid;
    mtfd_pkg::t_result n_out;
    mtfd_pkg::t_result n_skid;
    logic              out_free;

    // Refill the output from the skid word, else the input; else skid a push
    always_comb begin
        out_free     = !r_out_valid || !i_stall;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = i_push;
                n_skid       = i_data;
            end else begin
                n_out       = i_data;
                n_out_valid = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // The skid stage only fills behind a held output word
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word without output word");

    // No word is pushed while the skid stage is occupied
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skid_valid)
        else $error("push into full output queue");

endmodule

FILE: src/meter_teleinfo_frame_decoder.sv
`timescale 1ns / 1ps

// Historic-mode meter telemetry frame decoder.
// Input channel: one received byte per word (i_valid / o_stall); bit 7 is
// ignored. A word is taken at each edge with i_valid high and o_stall low.
// Output channel: one result word per good group, frame end, connection end
// or error (o_valid / i_stall), fields on separate ports.
// Configuration: i_cfg_valid / o_cfg_ready write the frame character limit;
// ready is always high, write only while the block is idle.
// A result is registered in the output register, or in the skid register
// while the output is stalled. Throughput: one byte per cycle while o_stall
// is low, set by the single registered update of the line state.
// Stalls: a two-word output queue sits behind the decoder; o_stall rises only
// when a second result waits behind a stalled one, so bytes that give no
// result keep flowing until then.
// Reset: the block hunts for STX, the limit returns to 280 and the output
// queue empties.
module meter_teleinfo_frame_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [9:0]  i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_event_res,
    output logic [3:0]  o_field_id,
    output logic [29:0] o_number_value,
    output logic [63:0] o_text_head,
    output logic [31:0] o_text_tail,
    output logic [3:0]  o_text_length,
    output logic [9:0]  o_group_number
);

    localparam int NL = mtfd_pkg::NUM_LABELS;

    logic [9:0]          r_frame_limit;
    logic                r_in_frame;
    logic [9:0]          r_frame_cnt;
    logic [5:0]          r_line_pos;
    logic [5:0]          r_sum;
    logic [6:0]          r_prev0;
    logic [6:0]          r_prev1;
    logic [NL-1:0]       r_match;
    logic                r_space;
    logic [29:0]         r_num;
    logic                r_digits_open;
    logic [3:0]          r_val_cnt;
    logic [6:0]          r_val_text [mtfd_pkg::TEXT_SLOTS];
    logic [9:0]          r_good_cnt;

    logic                n_in_frame;
    logic [9:0]          n_frame_cnt;
    logic [5:0]          n_line_pos;
    logic [5:0]          n_sum;
    logic [6:0]          n_prev0;
    logic [6:0]          n_prev1;
    logic [NL-1:0]       n_match;
    logic                n_space;
    logic [29:0]         n_num;
    logic                n_digits_open;
    logic [3:0]          n_val_cnt;
    logic [9:0]          n_good_cnt;

    logic                accept;
    logic                queue_full;
    logic [6:0]          b;
    logic                res_valid;
    mtfd_pkg::t_result   res;
    mtfd_pkg::t_result   out_word;
    logic                line_clear;
    logic                text_we;

    // commit of the character two places back
    logic [6:0]          c;
    logic [5:0]          idx;
    logic [63:0]         lt;
    logic [NL-1:0]       cm_match;
    logic [33:0]         num_wide;
    logic [29:0]         num_next;
    logic                is_digit;

    // line close
    logic [5:0]          body;
    logic                csum_ok;
    logic                hit;
    logic [3:0]          found;

    assign accept      = i_valid && !queue_full;
    assign o_stall     = queue_full;
    assign o_cfg_ready = 1'b1;
    assign b           = i_rx_byte[6:0];

    // Label prefix check and number accumulation for the committed character
    always_comb begin
        c   = r_prev1;
        idx = r_line_pos - 6'd2;
        lt  = '0;
        cm_match = r_match;
        for (int k = 0; k < NL; k++) begin
            lt = mtfd_pkg::label_text(4'(k));
            if ((idx < {2'b00, mtfd_pkg::label_len(4'(k))})
                && (lt[(7 - idx[2:0]) * 8 +: 7] != c)) begin
                cm_match[k] = 1'b0;
            end
        end
        is_digit = (c >= mtfd_pkg::CH_ZERO) && (c <= mtfd_pkg::CH_NINE);
        num_wide = ({4'b0000, r_num} << 3) + ({4'b0000, r_num} << 1)
                   + {30'd0, c[3:0]};
        num_next = (num_wide > mtfd_pkg::NUM_MAX) ? mtfd_pkg::NUM_MAX[29:0]
                                                  : num_wide[29:0];
    end

    // Checksum and first matching label for the line being closed
    always_comb begin
        body    = r_line_pos - 6'd2;
        csum_ok = ({1'b0, r_sum} + mtfd_pkg::CSUM_OFFSET) == r_prev0;
        hit     = 1'b0;
        found   = '0;
        for (int k = 0; k < NL; k++) begin
            if (!hit && r_match[k]
                && ({2'b00, mtfd_pkg::label_len(4'(k))} <= body)) begin
                hit   = 1'b1;
                found = 4'(k);
            end
        end
    end

    // Next state and result for the accepted byte
    always_comb begin
        n_in_frame    = r_in_frame;
        n_frame_cnt   = r_frame_cnt;
        n_line_pos    = r_line_pos;
        n_sum         = r_sum;
        n_prev0       = r_prev0;
        n_prev1       = r_prev1;
        n_match       = r_match;
        n_space       = r_space;
        n_num         = r_num;
        n_digits_open = r_digits_open;
        n_val_cnt     = r_val_cnt;
        n_good_cnt    = r_good_cnt;
        res           = '0;
        res.group_number = r_good_cnt;
        res_valid     = 1'b0;
        line_clear    = 1'b0;
        text_we       = 1'b0;

        if (accept) begin
            if (!r_in_frame) begin
                // hunt for start of frame
                if (b == mtfd_pkg::CH_STX) begin
                    n_in_frame  = 1'b1;
                    n_frame_cnt = '0;
                    n_good_cnt  = '0;
                    line_clear  = 1'b1;
                end
            end else if (r_frame_cnt >= r_frame_limit) begin
                res_valid     = 1'b1;
                res.event_res = mtfd_pkg::EV_FRAME_LONG;
            end else begin
                n_frame_cnt = r_frame_cnt + 10'd1;
                if (b == mtfd_pkg::CH_EOT) begin
                    res_valid     = 1'b1;
                    res.event_res = mtfd_pkg::EV_CONN_END;
                end else if (b == mtfd_pkg::CH_ETX) begin
                    res_valid     = 1'b1;
                    res.event_res = mtfd_pkg::EV_FRAME_END;
                end else if (b == mtfd_pkg::CH_LF) begin
                    line_clear = 1'b1;
                end else if (b == mtfd_pkg::CH_CR) begin
                    res_valid  = 1'b1;
                    line_clear = 1'b1;
                    if (r_line_pos < 6'd3 || !csum_ok) begin
                        res.event_res = mtfd_pkg::EV_CSUM_BAD;
                    end else if (!r_space || !hit) begin
                        res.event_res = mtfd_pkg::EV_LABEL_BAD;
                    end else begin
                        // good group: count it and report the value
                        if (r_good_cnt != 10'h3FF) begin
                            n_good_cnt = r_good_cnt + 10'd1;
                        end
                        res.event_res    = mtfd_pkg::EV_GROUP_OK;
                        res.field_id     = found;
                        res.number_value = mtfd_pkg::LABEL_NUMERIC[found] ? r_num : '0;
                        res.text_length  = r_val_cnt;
                        res.group_number = n_good_cnt;
                        for (int i = 0; i < mtfd_pkg::TEXT_SLOTS; i++) begin
                            if (4'(i) < r_val_cnt) begin
                                if (i < 8) begin
                                    res.text_head[8 * i +: 8] = {1'b0, r_val_text[i]};
                                end else begin
                                    res.text_tail[8 * (i - 8) +: 8] =
                                        {1'b0, r_val_text[i]};
                                end
                            end
                        end
                    end
                end else if (r_line_pos >= mtfd_pkg::MAX_LINE_CHARS) begin
                    res_valid     = 1'b1;
                    res.event_res = mtfd_pkg::EV_LINE_LONG;
                end else begin
                    // ordinary line character: commit the one two places back
                    if (r_line_pos >= 6'd2) begin
                        n_sum   = r_sum + {1'b0, c[4:0]} + {c[5], 5'b00000};
                        n_match = cm_match;
                        if (!r_space) begin
                            n_space = (c == mtfd_pkg::CH_SPACE);
                        end else begin
                            if (r_val_cnt < mtfd_pkg::TEXT_CHARS) begin
                                text_we   = 1'b1;
                                n_val_cnt = r_val_cnt + 4'd1;
                            end
                            if (r_digits_open && is_digit) begin
                                n_num = num_next;
                            end else begin
                                n_digits_open = 1'b0;
                            end
                        end
                    end
                    n_prev1    = r_prev0;
                    n_prev0    = b;
                    n_line_pos = r_line_pos + 6'd1;
                end
            end

            // any result but a good group returns to hunting
            if (res_valid && res.event_res != mtfd_pkg::EV_GROUP_OK) begin
                n_in_frame = 1'b0;
                line_clear = 1'b1;
            end
        end

        if (line_clear) begin
            n_line_pos    = '0;
            n_sum         = '0;
            n_prev0       = '0;
            n_prev1       = '0;
            n_match       = '1;
            n_space       = 1'b0;
            n_num         = '0;
            n_digits_open = 1'b1;
            n_val_cnt     = '0;
        end
    end

    // Hold decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_limit <= mtfd_pkg::FRAME_LIMIT_RESET;
            r_in_frame    <= 1'b0;
            r_frame_cnt   <= '0;
            r_line_pos    <= '0;
            r_sum         <= '0;
            r_prev0       <= '0;
            r_prev1       <= '0;
            r_match       <= '1;
            r_space       <= 1'b0;
            r_num         <= '0;
            r_digits_open <= 1'b1;
            r_val_cnt     <= '0;
            r_good_cnt    <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_frame_limit <= i_cfg_data;
            end
            r_in_frame    <= n_in_frame;
            r_frame_cnt   <= n_frame_cnt;
            r_line_pos    <= n_line_pos;
            r_sum         <= n_sum;
            r_prev0       <= n_prev0;
            r_prev1       <= n_prev1;
            r_match       <= n_match;
            r_space       <= n_space;
            r_num         <= n_num;
            r_digits_open <= n_digits_open;
            r_val_cnt     <= n_val_cnt;
            r_good_cnt    <= n_good_cnt;
        end
    end

    // Capture value characters
    always_ff @(posedge i_clk) begin
        if (text_we) begin
            r_val_text[r_val_cnt] <= c;
        end
    end

    mtfd_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_full  (queue_full),
        .o_valid (o_valid),
        .o_data  (out_word),
        .i_stall (i_stall)
    );

    assign o_event_res    = out_word.event_res;
    assign o_field_id     = out_word.field_id;
    assign o_number_value = out_word.number_value;
    assign o_text_head    = out_word.text_head;
    assign o_text_tail    = out_word.text_tail;
    assign o_text_length  = out_word.text_length;
    assign o_group_number = out_word.group_number;

    // While hunting no line is held
    a_hunt_line_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_line_pos == 6'd0 && r_val_cnt == 4'd0))
        else $error("line state left over while hunting");

    // The line never grows past its limit
    a_line_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_pos <= mtfd_pkg::MAX_LINE_CHARS)
        else $error("line position beyond limit");

    // Captured value text never exceeds its slots
    a_text_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_val_cnt <= mtfd_pkg::TEXT_CHARS)
        else $error("value count beyond capture limit");

endmodule
